// ----- design/tks_pkg.sv -----
// Package for top_k_smallest_heap: field widths, heap entry type, request codes
// and the command/status structs between controller and datapath.
// No dependencies.
package tks_pkg;

    localparam int SCORE_W   = 32;
    localparam int TAG_W     = 31;
    localparam int CAP_W     = 7;
    localparam int IDX_W     = 6;
    localparam int CAP_RESET = 16;

    localparam logic REQ_OFFER = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
    } t_entry;

    typedef struct packed {
        logic in_ready;   // idle, take an item beat
        logic rd_slot;    // read the requested slot
        logic rd_root;    // read slot 0
        logic root_take;  // replace root by the offer, start sift at 0
        logic append;     // store offer at the next free slot
        logic hp_step;    // next heapify position
        logic hp_load;    // load the heapify element
        logic sift_l;     // left child step
        logic sift_r;     // right child step
        logic sift_c;     // compare and move step
        logic finish;     // try to load the result register
    } t_cmd;

    typedef struct packed {
        logic in_fire;
        logic in_is_read;
        logic not_full;
        logic fill_last;
        logic root_less;
        logic j_zero;
        logic l_ok;
        logic sc_stop;
        logic out_free;
    } t_stat;

endpackage

// ----- design/tks_in_if.sv -----
// Input item channel of top_k_smallest_heap: valid/ready plus the request fields.
// Depends on tks_pkg.
interface tks_in_if import tks_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
    logic [IDX_W-1:0]   slot_index;

    modport source (output valid, req_type, score, tag, slot_index, input ready);
    modport sink   (input valid, req_type, score, tag, slot_index, output ready);
endinterface

// ----- design/tks_out_if.sv -----
// Result channel of top_k_smallest_heap: valid/ready plus the result fields.
// Depends on tks_pkg.
interface tks_out_if import tks_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               accepted;
    logic [SCORE_W-1:0] read_score;
    logic [TAG_W-1:0]   read_tag;
    logic               read_valid;
    logic [CAP_W-1:0]   entry_count;

    modport source (output valid, accepted, read_score, read_tag, read_valid, entry_count,
                    input ready);
    modport sink   (input valid, accepted, read_score, read_tag, read_valid, entry_count,
                    output ready);
endinterface

// ----- design/tks_cfg_if.sv -----
// Configuration write channel of top_k_smallest_heap: valid/ready plus capacity data.
// Depends on tks_pkg.
interface tks_cfg_if import tks_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- design/tks_ctrl.sv -----
// Controller of top_k_smallest_heap: one-hot sequencer for offer, read,
// heapify and sift-down. Depends on tks_pkg; drives tks_dp through t_cmd.
module tks_ctrl import tks_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_RD      = 11'b000_0000_0010,
        S_RT_RD   = 11'b000_0000_0100,
        S_RT_CMP  = 11'b000_0000_1000,
        S_APPEND  = 11'b000_0001_0000,
        S_HP_NEXT = 11'b000_0010_0000,
        S_HP_LOAD = 11'b000_0100_0000,
        S_SL      = 11'b000_1000_0000,
        S_SR      = 11'b001_0000_0000,
        S_SC      = 11'b010_0000_0000,
        S_FINISH  = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_hp, n_hp;
    t_state w_sift_ret;

    assign w_sift_ret = r_hp ? S_HP_NEXT : S_FINISH;

    always_comb begin
        n_state = r_state;
        n_hp    = r_hp;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_fire) begin
                    priority if (i_stat.in_is_read) n_state = S_RD;
                    else if (i_stat.not_full)       n_state = S_APPEND;
                    else                            n_state = S_RT_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_slot = 1'b1;
                n_state = S_FINISH;
            end
            S_RT_RD: begin
                o_cmd.rd_root = 1'b1;
                n_state = S_RT_CMP;
            end
            S_RT_CMP: begin
                if (i_stat.root_less) begin
                    o_cmd.root_take = 1'b1;
                    n_state = S_SL;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                if (i_stat.fill_last) begin
                    n_hp    = 1'b1;
                    n_state = S_HP_NEXT;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_HP_NEXT: begin
                if (i_stat.j_zero) begin
                    n_hp    = 1'b0;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.hp_step = 1'b1;
                    n_state = S_HP_LOAD;
                end
            end
            S_HP_LOAD: begin
                o_cmd.hp_load = 1'b1;
                n_state = S_SL;
            end
            S_SL: begin
                o_cmd.sift_l = 1'b1;
                n_state = i_stat.l_ok ? S_SR : w_sift_ret;
            end
            S_SR: begin
                o_cmd.sift_r = 1'b1;
                n_state = S_SC;
            end
            S_SC: begin
                o_cmd.sift_c = 1'b1;
                n_state = i_stat.sc_stop ? w_sift_ret : S_SL;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
                n_hp    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hp    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hp    <= n_hp;
        end
    end

endmodule

// ----- design/tks_dp.sv -----
// Datapath of top_k_smallest_heap: heap memory, count, capacity, sift registers
// and result register. Depends on tks_pkg and the channel interfaces.
module tks_dp import tks_pkg::*; #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    tks_in_if.sink      i_item,
    tks_out_if.source   o_result,
    tks_cfg_if.sink     i_cfg
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int EW = (AW + 2 > 8) ? AW + 2 : 8;

    function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] v);
        logic [EW-1:0] ve;
        ve = EW'(v);
        if (v == '0)                         return CAP_W'(1);
        else if (ve > EW'(MAX_ENTRIES))      return CAP_W'(MAX_ENTRIES);
        else                                 return v;
    endfunction

    t_entry r_mem [MAX_ENTRIES];
    t_entry r_rdata;

    logic [CAP_W-1:0] r_cap;
    logic [CAP_W-1:0] r_count;
    logic             r_req;
    logic [IDX_W-1:0] r_idx;
    t_entry           r_v;
    t_entry           r_left;
    logic [AW-1:0]    r_pos;
    logic [AW-1:0]    r_j;
    logic             r_acc;

    logic             r_out_valid;
    logic             r_out_acc;
    t_entry           r_out_ent;
    logic             r_out_rv;
    logic [CAP_W-1:0] r_out_cnt;

    logic             w_ren;
    logic [AW-1:0]    w_raddr;
    logic             w_wen;
    logic [AW-1:0]    w_waddr;
    t_entry           w_wdata;

    logic [EW-1:0]    w_cap_e, w_cnt_e, w_idx_e, w_l_e, w_r_e;
    logic [AW-1:0]    w_cnt_a, w_idx_a, w_l_a, w_r_a, w_jm1;
    logic             w_l_ok, w_r_ok, w_big_l, w_big_r;
    logic [SCORE_W-1:0] w_best;
    logic             w_in_fire, w_cfg_fire, w_rv;
    logic [CAP_W-1:0] w_new_cap;

    assign w_cap_e = EW'(r_cap);
    assign w_cnt_e = EW'(r_count);
    assign w_idx_e = EW'(r_idx);
    assign w_l_e   = EW'({r_pos, 1'b1});
    assign w_r_e   = w_l_e + EW'(1);
    assign w_cnt_a = w_cnt_e[AW-1:0];
    assign w_idx_a = w_idx_e[AW-1:0];
    assign w_l_a   = w_l_e[AW-1:0];
    assign w_r_a   = w_r_e[AW-1:0];
    assign w_jm1   = r_j - AW'(1);
    assign w_l_ok  = w_l_e < w_cap_e;
    assign w_r_ok  = w_r_e < w_cap_e;

    assign w_big_l = r_left.score > r_v.score;
    assign w_best  = w_big_l ? r_left.score : r_v.score;
    assign w_big_r = w_r_ok && (r_rdata.score > w_best);

    assign w_in_fire  = i_item.valid && i_item.ready;
    assign w_cfg_fire = i_cfg.valid && i_cfg.ready;
    assign w_new_cap  = eff_cap(i_cfg.data);
    assign w_rv       = (r_req == REQ_READ) && (EW'(r_idx) < w_cnt_e);

    assign i_item.ready = i_cmd.in_ready;
    assign i_cfg.ready  = 1'b1;

    assign o_stat.in_fire    = w_in_fire;
    assign o_stat.in_is_read = (i_item.req_type == REQ_READ);
    assign o_stat.not_full   = r_count < r_cap;
    assign o_stat.fill_last  = CAP_W'(r_count + CAP_W'(1)) == r_cap;
    assign o_stat.root_less  = r_v.score < r_rdata.score;
    assign o_stat.j_zero     = (r_j == '0);
    assign o_stat.l_ok       = w_l_ok;
    assign o_stat.sc_stop    = !w_big_l && !w_big_r;
    assign o_stat.out_free   = !r_out_valid || o_result.ready;

    always_comb begin
        w_ren   = 1'b0;
        w_raddr = '0;
        w_wen   = 1'b0;
        w_waddr = r_pos;
        w_wdata = r_v;
        priority if (i_cmd.rd_slot) begin
            w_ren   = w_rv;
            w_raddr = w_idx_a;
        end else if (i_cmd.rd_root) begin
            w_ren   = 1'b1;
        end else if (i_cmd.hp_step) begin
            w_ren   = 1'b1;
            w_raddr = w_jm1;
        end else if (i_cmd.append) begin
            w_wen   = 1'b1;
            w_waddr = w_cnt_a;
        end else if (i_cmd.sift_l) begin
            w_ren   = w_l_ok;
            w_raddr = w_l_a;
            w_wen   = !w_l_ok;
        end else if (i_cmd.sift_r) begin
            w_ren   = w_r_ok;
            w_raddr = w_r_a;
        end else if (i_cmd.sift_c) begin
            w_wen   = 1'b1;
            priority if (w_big_r) w_wdata = r_rdata;
            else if (w_big_l)     w_wdata = r_left;
            else                  w_wdata = r_v;
        end else begin
            w_ren   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wen) r_mem[w_waddr] <= w_wdata;
        if (w_ren) r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_req     <= i_item.req_type;
            r_idx     <= i_item.slot_index;
            r_v.score <= i_item.score;
            r_v.tag   <= i_item.tag;
        end else if (i_cmd.hp_load) begin
            r_v <= r_rdata;
        end
        if (i_cmd.root_take || i_cmd.append) r_pos <= '0;
        else if (i_cmd.hp_step)              r_pos <= w_jm1;
        else if (i_cmd.sift_c) begin
            if (w_big_r)      r_pos <= w_r_a;
            else if (w_big_l) r_pos <= w_l_a;
        end
        if (i_cmd.append)       r_j <= w_cap_e[AW:1];
        else if (i_cmd.hp_step) r_j <= w_jm1;
        if (i_cmd.sift_r) r_left <= r_rdata;
        if (i_cmd.finish && o_stat.out_free) begin
            r_out_acc <= r_acc;
            r_out_rv  <= w_rv;
            r_out_ent <= w_rv ? r_rdata : '0;
            r_out_cnt <= r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= eff_cap(CAP_W'(CAP_RESET));
            r_count     <= '0;
            r_acc       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_fire) begin
                r_cap <= w_new_cap;
                if (r_count > w_new_cap) r_count <= w_new_cap;
            end else if (i_cmd.append) begin
                r_count <= CAP_W'(r_count + CAP_W'(1));
            end
            if (w_in_fire)                            r_acc <= 1'b0;
            else if (i_cmd.append || i_cmd.root_take) r_acc <= 1'b1;
            if (i_cmd.finish && o_stat.out_free) r_out_valid <= 1'b1;
            else if (o_result.ready)             r_out_valid <= 1'b0;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.accepted    = r_out_acc;
    assign o_result.read_score  = r_out_ent.score;
    assign o_result.read_tag    = r_out_ent.tag;
    assign o_result.read_valid  = r_out_rv;
    assign o_result.entry_count = r_out_cnt;

endmodule

// ----- design/top_k_smallest_heap.sv -----
// Top level of top_k_smallest_heap: keeps the smallest scored tags in a max-heap.
// Depends on tks_pkg, tks_in_if, tks_out_if, tks_cfg_if, tks_ctrl and tks_dp.
//
//  channel   dir  fields
//  i_item    in   req_type, score, tag, slot_index
//  o_result  out  accepted, read_score, read_tag, read_valid, entry_count
//  i_cfg     in   data = capacity (always ready)
//
// One item at a time. Read: idle, slot read, finish. Append: idle, store, finish,
// plus the heap build on the filling beat (a sift from each slot below capacity/2,
// each level a left fetch, right fetch and compare). Replace offer: idle, root read,
// compare, then the same sift when taken (one memory read port, left and right child fetched in turn).
// Synchronous active-low reset; the heap memory is not cleared. A result waits in
// its register while o_result stalls; the next beat is taken meanwhile.
module top_k_smallest_heap import tks_pkg::*; #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tks_in_if.sink    i_item,
    tks_out_if.source o_result,
    tks_cfg_if.sink   i_cfg
);

    t_cmd  w_cmd;
    t_stat w_stat;

    tks_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    tks_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .i_item   (i_item),
        .o_result (o_result),
        .i_cfg    (i_cfg)
    );

endmodule

// ----- sim/top_k_smallest_heap_tb.sv -----
// Self-checking testbench for top_k_smallest_heap: random offers and slot reads
// against an in-bench heap predictor, under several capacities and stall mixes.
// Depends on tks_pkg, tks_in_if, tks_out_if, tks_cfg_if and the top level.
module top_k_smallest_heap_tb import tks_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP_DEPTH = 64;

    typedef struct packed {
        logic               req_type;
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
        logic [IDX_W-1:0]   slot_index;
    } t_item;

    typedef struct packed {
        logic               accepted;
        logic [SCORE_W-1:0] read_score;
        logic [TAG_W-1:0]   read_tag;
        logic               read_valid;
        logic [CAP_W-1:0]   entry_count;
    } t_outcome;

    logic clk = 1'b0;
    logic rst_n;

    tks_in_if  item_if ();
    tks_out_if res_if ();
    tks_cfg_if cfg_if ();

    top_k_smallest_heap #(.MAX_ENTRIES(HEAP_DEPTH)) i_dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_if.sink),
        .o_result (res_if.source),
        .i_cfg    (cfg_if.sink)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predicted heap contents and register
    logic [SCORE_W-1:0] heap_sc [HEAP_DEPTH];
    logic [TAG_W-1:0]   heap_tg [HEAP_DEPTH];
    int unsigned        held;
    logic [CAP_W-1:0]   cap_reg;

    t_item    item_q[$];
    t_outcome outcome_q[$];
    int       err_count;
    int       tx_idle_pct;
    int       rx_stall_pct;
    logic     rx_hold;

    function automatic int unsigned eff_capacity(logic [CAP_W-1:0] v);
        if (v == '0) return 1;
        if (v > HEAP_DEPTH) return HEAP_DEPTH;
        return v;
    endfunction

    function automatic void sift_down(int unsigned n, int unsigned pos);
        int unsigned        big, l, r;
        logic [SCORE_W-1:0] ts;
        logic [TAG_W-1:0]   tt;
        while (pos < n) begin
            big = pos;
            l   = 2 * pos + 1;
            r   = l + 1;
            if (l < n && heap_sc[l] > heap_sc[big]) big = l;
            if (r < n && heap_sc[r] > heap_sc[big]) big = r;
            if (big == pos) break;
            ts           = heap_sc[pos];
            tt           = heap_tg[pos];
            heap_sc[pos] = heap_sc[big];
            heap_tg[pos] = heap_tg[big];
            heap_sc[big] = ts;
            heap_tg[big] = tt;
            pos          = big;
        end
    endfunction

    function automatic void apply_capacity(logic [CAP_W-1:0] v);
        cap_reg = v;
        if (held > eff_capacity(v)) held = eff_capacity(v);
    endfunction

    function automatic t_outcome heap_apply(t_item it);
        t_outcome    o;
        int unsigned cap;
        o   = '0;
        cap = eff_capacity(cap_reg);
        if (it.req_type == REQ_OFFER) begin
            if (held < cap) begin
                heap_sc[held] = it.score;
                heap_tg[held] = it.tag;
                held++;
                o.accepted = 1'b1;
                if (held == cap) begin
                    for (int j = int'(cap / 2) - 1; j >= 0; j--) sift_down(cap, j);
                end
            end else if (it.score < heap_sc[0]) begin
                heap_sc[0] = it.score;
                heap_tg[0] = it.tag;
                sift_down(cap, 0);
                o.accepted = 1'b1;
            end
        end else if (it.slot_index < held) begin
            o.read_score = heap_sc[it.slot_index];
            o.read_tag   = heap_tg[it.slot_index];
            o.read_valid = 1'b1;
        end
        o.entry_count = CAP_W'(held);
        return o;
    endfunction

    function automatic logic [SCORE_W-1:0] random_score();
        case ($urandom_range(9))
            0, 1, 2: return SCORE_W'($urandom_range(15));
            3: begin
                case ($urandom_range(3))
                    0: return '0;
                    1: return '1;
                    2: return 32'h8000_0000;
                    default: return 32'h7FC0_0000 | SCORE_W'($urandom_range(255));
                endcase
            end
            4: return 32'h3F80_0000 + SCORE_W'($urandom_range(255));
            default: return $urandom;
        endcase
    endfunction

    function automatic t_item random_item(int unsigned cap);
        t_item it;
        it.req_type   = ($urandom_range(99) < 30) ? REQ_READ : REQ_OFFER;
        it.score      = random_score();
        it.tag        = TAG_W'($urandom);
        it.slot_index = $urandom_range(1) ? IDX_W'($urandom_range(cap)) : IDX_W'($urandom);
        return it;
    endfunction

    function automatic t_item mk(logic rq, logic [SCORE_W-1:0] sc, logic [TAG_W-1:0] tg,
                                 logic [IDX_W-1:0] ix);
        t_item it;
        it.req_type   = rq;
        it.score      = sc;
        it.tag        = tg;
        it.slot_index = ix;
        return it;
    endfunction

    // Item driver
    always @(posedge clk) begin : item_driver
        t_item cur;
        if (!rst_n) begin
            item_if.valid <= 1'b0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                cur = mk(item_if.req_type, item_if.score, item_if.tag, item_if.slot_index);
                outcome_q.push_back(heap_apply(cur));
            end
            if (!item_if.valid || item_if.ready) begin
                if (item_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    cur = item_q.pop_front();
                    item_if.valid      <= 1'b1;
                    item_if.req_type   <= cur.req_type;
                    item_if.score      <= cur.score;
                    item_if.tag        <= cur.tag;
                    item_if.slot_index <= cur.slot_index;
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge clk) begin : result_monitor
        t_outcome got, want;
        if (!rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got.accepted    = res_if.accepted;
                got.read_score  = res_if.read_score;
                got.read_tag    = res_if.read_tag;
                got.read_valid  = res_if.read_valid;
                got.entry_count = res_if.entry_count;
                if (outcome_q.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected beat acc=%0b sc=%h tag=%h rv=%0b cnt=%0d",
                             $time, got.accepted, got.read_score, got.read_tag,
                             got.read_valid, got.entry_count);
                end else begin
                    want = outcome_q.pop_front();
                    if (got.accepted !== want.accepted || got.read_score !== want.read_score
                        || got.read_tag !== want.read_tag
                        || got.read_valid !== want.read_valid
                        || got.entry_count !== want.entry_count) begin
                        err_count++;
                        $display("%0t: expected acc=%0b sc=%h tag=%h rv=%0b cnt=%0d",
                                 $time, want.accepted, want.read_score, want.read_tag,
                                 want.read_valid, want.entry_count);
                        $display("%0t: actual   acc=%0b sc=%h tag=%h rv=%0b cnt=%0d",
                                 $time, got.accepted, got.read_score, got.read_tag,
                                 got.read_valid, got.entry_count);
                    end
                end
            end
            res_if.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic wait_idle();
        while (item_q.size() != 0 || item_if.valid || outcome_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        apply_capacity(v);
    endtask

    task automatic hold_receiver(input int cycles);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge clk);
        rx_hold <= 1'b0;
    endtask

    task automatic run_phase(input logic [CAP_W-1:0] cap, input int tx_pct, input int rx_pct,
                             input int n, input int hold_cycles, input bit mid_pause);
        int unsigned ecap;
        ecap = eff_capacity(cap);
        write_capacity(cap);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        if (hold_cycles > 0) begin
            fork
                hold_receiver(hold_cycles);
            join_none
        end
        for (int k = 0; k < n; k++) begin
            if (mid_pause && k == n / 2) wait_idle();
            item_q.push_back(random_item(ecap));
        end
        wait_idle();
    endtask

    initial begin
        item_if.valid      = 1'b0;
        item_if.req_type   = REQ_OFFER;
        item_if.score      = '0;
        item_if.tag        = '0;
        item_if.slot_index = '0;
        res_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.data        = '0;
        rx_hold            = 1'b0;
        tx_idle_pct        = 0;
        rx_stall_pct       = 0;
        err_count          = 0;
        held               = 0;
        cap_reg            = CAP_W'(CAP_RESET);
        for (int k = 0; k < HEAP_DEPTH; k++) begin
            heap_sc[k] = '0;
            heap_tg[k] = '0;
        end
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset capacity, cut to one, saturate, shrink without rebuild, build
        item_q.push_back(mk(REQ_OFFER, '1, '0, '0));
        item_q.push_back(mk(REQ_OFFER, '0, '1, '1));
        wait_idle();
        write_capacity(7'd0);
        item_q.push_back(mk(REQ_OFFER, '1, 31'h5555_5555, '0));
        item_q.push_back(mk(REQ_OFFER, 32'd7, 31'h2AAA_AAAA, '0));
        item_q.push_back(mk(REQ_READ, '0, '0, 6'd0));
        item_q.push_back(mk(REQ_READ, '0, '0, 6'd1));
        wait_idle();
        write_capacity(7'd127);
        item_q.push_back(mk(REQ_OFFER, 32'h8000_0000, 31'd1, '0));
        item_q.push_back(mk(REQ_OFFER, 32'h7FC0_0000, 31'd2, '0));
        item_q.push_back(mk(REQ_OFFER, 32'h7F80_0000, 31'd3, '0));
        item_q.push_back(mk(REQ_OFFER, 32'd3, 31'd4, '0));
        item_q.push_back(mk(REQ_OFFER, 32'd9, 31'd5, '0));
        item_q.push_back(mk(REQ_READ, '0, '0, 6'd5));
        item_q.push_back(mk(REQ_READ, '0, '0, 6'd6));
        wait_idle();
        write_capacity(7'd3);
        item_q.push_back(mk(REQ_OFFER, 32'd5, 31'd6, '1));
        item_q.push_back(mk(REQ_READ, '0, '0, 6'd0));
        item_q.push_back(mk(REQ_READ, '0, '0, 6'd1));
        item_q.push_back(mk(REQ_READ, '1, '1, 6'd2));
        wait_idle();
        write_capacity(7'd4);
        item_q.push_back(mk(REQ_OFFER, 32'd2, 31'd7, '0));
        item_q.push_back(mk(REQ_READ, '0, '0, 6'd0));
        item_q.push_back(mk(REQ_READ, '0, '0, 6'd63));
        wait_idle();

        run_phase(7'd64,  0,  0,  110, 0,   1'b0);
        run_phase(7'd5,   59, 0,  120, 0,   1'b0);
        run_phase(7'd1,   0,  59, 80,  0,   1'b0);
        run_phase(7'd65,  16, 16, 120, 0,   1'b0);
        run_phase(7'd2,   0,  0,  100, 300, 1'b0);
        run_phase(CAP_W'($urandom_range(1, 127)), 59, 0, 100, 0, 1'b1);
        run_phase(7'd8,   0,  59, 100, 0,   1'b1);
        run_phase(7'd0,   16, 16, 60,  0,   1'b0);
        run_phase(7'd33,  0,  0,  80,  0,   1'b0);

        repeat (60) @(posedge clk);
        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
